// File: hdl/button_digit_entry_editor_unit_defines.svh
// Assertion macros for the button digit entry editor checker
`ifndef BUTTON_DIGIT_ENTRY_EDITOR_UNIT_DEFINES_SVH
`define BUTTON_DIGIT_ENTRY_EDITOR_UNIT_DEFINES_SVH

// check cons in the same cycle as ante
`define BDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define BDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bde_pkg.sv
// Types and constants shared by the button digit entry editor
package bde_pkg;

  localparam int NUM_DIGITS = 12;
  localparam int DIGIT_W    = 4;
  localparam int CURSOR_W   = 4;

  localparam logic [DIGIT_W-1:0]  DIGIT_MAX = 4'd9;
  localparam logic [CURSOR_W-1:0] LAST_IP   = 4'd11;
  localparam logic [CURSOR_W-1:0] LAST_NUM  = 4'd3;

  localparam logic MODE_IP  = 1'b0;
  localparam logic MODE_NUM = 1'b1;

  localparam int BTN_LEFT  = 0;
  localparam int BTN_UP    = 1;
  localparam int BTN_DOWN  = 2;
  localparam int BTN_RIGHT = 3;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic refresh_tick;
    logic btn_left;
    logic btn_up;
    logic btn_down;
    logic btn_right;
  } bde_in_t;

  typedef struct packed {
    logic [3:0]  cursor_pos;
    logic [47:0] digits_packed;
    logic        entry_done;
    logic [13:0] number_value;
    logic [7:0]  octet_first;
    logic [7:0]  octet_second;
    logic [7:0]  octet_third;
    logic [7:0]  octet_fourth;
    logic        octet_overflow;
  } bde_out_t;

  typedef struct packed {
    digit_t [NUM_DIGITS-1:0] digits;
    logic [CURSOR_W-1:0]     cursor;
    logic [3:0]              prev;
  } bde_state_t;

  function automatic logic [9:0] group_value(digit_t a, digit_t b, digit_t c);
    return {6'd0, a} * 10'd100 + {6'd0, b} * 10'd10 + {6'd0, c};
  endfunction

endpackage

// File: hdl/bde_ifs.sv
// Valid/ready channel interfaces for input, result and configuration
interface bde_in_if import bde_pkg::*; ();
  logic    valid;
  logic    ready;
  bde_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bde_out_if import bde_pkg::*; ();
  logic     valid;
  logic     ready;
  bde_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bde_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/bde_step.sv
// Per-tick update: edge detect, cursor move, digit edit and confirm values
module bde_step import bde_pkg::*; (
  input  bde_state_t state,
  input  logic       mode,
  input  bde_in_t    item,
  output bde_state_t state_nxt,
  output bde_out_t   result
);

  logic [3:0]          now;
  logic [3:0]          rise;
  logic [CURSOR_W-1:0] last;
  logic [CURSOR_W-1:0] cur;
  digit_t              d;
  logic [47:0]         packed_d;
  logic [9:0]          grp [4];

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      packed_d[47-4*i -: 4] = state.digits[i];
    end
    for (int g = 0; g < 4; g++) begin
      grp[g] = group_value(state.digits[3*g], state.digits[3*g+1], state.digits[3*g+2]);
    end
  end

  always_comb begin
    now = '0;
    now[BTN_LEFT]  = item.btn_left;
    now[BTN_UP]    = item.btn_up;
    now[BTN_DOWN]  = item.btn_down;
    now[BTN_RIGHT] = item.btn_right;
    rise = now & ~state.prev;
    last = (mode == MODE_NUM) ? LAST_NUM : LAST_IP;

    state_nxt = state;
    result = '0;
    result.digits_packed = packed_d;
    result.cursor_pos = state.cursor;
    cur = state.cursor;
    d = '0;

    if (item.refresh_tick) begin
      if (now[BTN_LEFT] && now[BTN_RIGHT]) begin
        result.cursor_pos = '0;
        result.entry_done = 1'b1;
        if (mode == MODE_NUM) begin
          result.number_value = {10'd0, state.digits[0]} * 14'd1000
                              + {10'd0, state.digits[1]} * 14'd100
                              + {10'd0, state.digits[2]} * 14'd10
                              + {10'd0, state.digits[3]};
        end else begin
          result.octet_first    = grp[0][7:0];
          result.octet_second   = grp[1][7:0];
          result.octet_third    = grp[2][7:0];
          result.octet_fourth   = grp[3][7:0];
          result.octet_overflow = (grp[0] > 10'd255) || (grp[1] > 10'd255) ||
                                  (grp[2] > 10'd255) || (grp[3] > 10'd255);
        end
        state_nxt = '0;
      end else begin
        if (rise[BTN_LEFT] && (cur != '0)) begin
          cur = cur - 4'd1;
        end
        if (rise[BTN_RIGHT] && (cur < last)) begin
          cur = cur + 4'd1;
        end
        if (cur < 4'(NUM_DIGITS)) begin
          d = state.digits[cur];
          if (rise[BTN_UP]) begin
            d = (d == DIGIT_MAX) ? '0 : d + 4'd1;
          end
          if (rise[BTN_DOWN]) begin
            d = (d == '0) ? DIGIT_MAX : d - 4'd1;
          end
          state_nxt.digits[cur] = d;
        end
        state_nxt.cursor = cur;
        state_nxt.prev = now;
        result.cursor_pos = cur;
        for (int i = 0; i < NUM_DIGITS; i++) begin
          result.digits_packed[47-4*i -: 4] = state_nxt.digits[i];
        end
      end
    end
  end

endmodule

// File: hdl/button_digit_entry_editor_unit.sv
// Button digit entry editor: one transaction per cycle, each tick updates the
// digit store, cursor and button edge memory at once and yields its result in the
// next cycle from the result register. A transaction is taken every cycle
// while the result register is empty or its result is taken in that cycle; a
// stalled result holds the input side. Mode 0 gives four IPv4 octets, mode 1
// a number 0..9999, both on the tick where left and right are held together.
module button_digit_entry_editor_unit import bde_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bde_in_if.sink    in_chan,
  bde_out_if.source out_chan,
  bde_cfg_if.sink   cfg_chan
);

  bde_state_t state_r;
  bde_state_t state_nxt;
  logic       mode_r;
  logic       out_valid_r;
  bde_out_t   out_data_r;
  bde_out_t   result;
  logic       accept;

  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign accept         = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  bde_step u_step (
    .state     (state_r),
    .mode      (mode_r),
    .item      (in_chan.data),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      mode_r      <= MODE_IP;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        mode_r <= cfg_chan.data;
      end
      if (accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

endmodule

// File: hdl/bde_checker.sv
// Port-level checker for the button digit entry editor, with its bind
`include "button_digit_entry_editor_unit_defines.svh"

module bde_checker import bde_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input bde_out_t out_data
);

  `BDE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `BDE_ASSERT_NOW(a_ready_empty, !out_valid, in_ready, "input stalled with empty result register")
  `BDE_ASSERT_NOW(a_done_cursor, out_valid && out_data.entry_done, out_data.cursor_pos == 4'd0, "cursor not cleared on confirm")
  `BDE_ASSERT_NOW(a_idle_values, out_valid && !out_data.entry_done, (out_data.number_value == 14'd0) && (out_data.octet_first == 8'd0) && (out_data.octet_fourth == 8'd0) && !out_data.octet_overflow, "value fields set without confirm")
  `BDE_ASSERT_NOW(a_cursor_range, out_valid, out_data.cursor_pos <= LAST_IP, "cursor beyond last digit")

endmodule

bind button_digit_entry_editor_unit bde_checker u_bde_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

// File: bench/button_digit_entry_editor_unit_tb.sv
// Self-checking testbench for the button digit entry editor, with its own shadow of the editor
module button_digit_entry_editor_unit_tb import bde_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_TICKS   = 2000;

  localparam logic [3:0] PRESS_NONE  = 4'b0000;
  localparam logic [3:0] PRESS_LEFT  = 4'b0001 << BTN_LEFT;
  localparam logic [3:0] PRESS_UP    = 4'b0001 << BTN_UP;
  localparam logic [3:0] PRESS_DOWN  = 4'b0001 << BTN_DOWN;
  localparam logic [3:0] PRESS_RIGHT = 4'b0001 << BTN_RIGHT;
  localparam logic [3:0] PRESS_ENTER = PRESS_LEFT | PRESS_RIGHT;

  logic clk = 1'b0;
  logic rst_n;

  bde_in_if  in_chan ();
  bde_out_if out_chan ();
  bde_cfg_if cfg_chan ();

  button_digit_entry_editor_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  digit_t          shadow_digits [NUM_DIGITS];
  logic [3:0]      shadow_cursor;
  logic [3:0]      shadow_prev;
  logic            shadow_mode;
  bde_out_t        pending_results [$];

  int  ticks_sent;
  int  ticks_checked;
  int  error_count;
  int  confirm_count;
  int  overflow_count;
  int  mode_writes;
  int  idle_cycles;
  int  stall_left;
  int  right_bias = 40;
  bit  idle_enable = 1'b1;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [47:0] pack_shadow();
    logic [47:0] p;
    p = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      p = {p[43:0], shadow_digits[i]};
    end
    return p;
  endfunction

  function automatic bde_out_t next_editor_result(bde_in_t t);
    bde_out_t   r;
    logic [3:0] now;
    logic [3:0] rise;
    logic [3:0] last;
    logic [7:0] oct [4];
    int         g;
    digit_t     d;
    r = '0;
    if (!t.refresh_tick) begin
      r.cursor_pos    = shadow_cursor;
      r.digits_packed = pack_shadow();
      return r;
    end
    now            = PRESS_NONE;
    now[BTN_LEFT]  = t.btn_left;
    now[BTN_UP]    = t.btn_up;
    now[BTN_DOWN]  = t.btn_down;
    now[BTN_RIGHT] = t.btn_right;
    if ((now & PRESS_ENTER) == PRESS_ENTER) begin
      r.digits_packed = pack_shadow();
      r.entry_done    = 1'b1;
      if (shadow_mode == MODE_NUM) begin
        g = int'(shadow_digits[0]) * 1000 + int'(shadow_digits[1]) * 100 +
            int'(shadow_digits[2]) * 10 + int'(shadow_digits[3]);
        r.number_value = g[13:0];
      end else begin
        for (int k = 0; k < 4; k++) begin
          g = int'(shadow_digits[3*k]) * 100 + int'(shadow_digits[3*k+1]) * 10 +
              int'(shadow_digits[3*k+2]);
          oct[k] = g[7:0];
          if (g > 255) r.octet_overflow = 1'b1;
        end
        r.octet_first  = oct[0];
        r.octet_second = oct[1];
        r.octet_third  = oct[2];
        r.octet_fourth = oct[3];
      end
      foreach (shadow_digits[i]) shadow_digits[i] = '0;
      shadow_cursor = '0;
      shadow_prev   = PRESS_NONE;
      return r;
    end
    rise = now & ~shadow_prev;
    last = (shadow_mode == MODE_NUM) ? LAST_NUM : LAST_IP;
    if (rise[BTN_LEFT] && shadow_cursor > 0) shadow_cursor = shadow_cursor - 1'b1;
    if (rise[BTN_RIGHT] && shadow_cursor < last) shadow_cursor = shadow_cursor + 1'b1;
    if (shadow_cursor < NUM_DIGITS) begin
      d = shadow_digits[shadow_cursor];
      if (rise[BTN_UP]) d = (d == DIGIT_MAX) ? digit_t'(0) : digit_t'(d + 1'b1);
      if (rise[BTN_DOWN]) d = (d == 0) ? DIGIT_MAX : digit_t'(d - 1'b1);
      shadow_digits[shadow_cursor] = d;
    end
    shadow_prev     = now;
    r.cursor_pos    = shadow_cursor;
    r.digits_packed = pack_shadow();
    return r;
  endfunction

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    bde_out_t want;
    bde_out_t got;
    if (rst_n) begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        shadow_mode = cfg_chan.data;
        mode_writes++;
      end
      if (out_chan.valid && out_chan.ready) begin
        got = out_chan.data;
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("cursor_pos", want.cursor_pos, got.cursor_pos);
          check_field("digits_packed", want.digits_packed, got.digits_packed);
          check_field("entry_done", want.entry_done, got.entry_done);
          check_field("number_value", want.number_value, got.number_value);
          check_field("octet_first", want.octet_first, got.octet_first);
          check_field("octet_second", want.octet_second, got.octet_second);
          check_field("octet_third", want.octet_third, got.octet_third);
          check_field("octet_fourth", want.octet_fourth, got.octet_fourth);
          check_field("octet_overflow", want.octet_overflow, got.octet_overflow);
        end
        ticks_checked++;
      end
      if (in_chan.valid && in_chan.ready) begin
        want = next_editor_result(in_chan.data);
        if (want.entry_done) confirm_count++;
        if (want.octet_overflow) overflow_count++;
        pending_results.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (!idle_enable) begin
      out_chan.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_chan.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("button_digit_entry_editor_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic bde_in_t tick_of(logic refresh, logic [3:0] btns);
    bde_in_t t;
    t.refresh_tick = refresh;
    t.btn_left     = btns[BTN_LEFT];
    t.btn_up       = btns[BTN_UP];
    t.btn_down     = btns[BTN_DOWN];
    t.btn_right    = btns[BTN_RIGHT];
    return t;
  endfunction

  task automatic send_tick(bde_in_t t);
    int gap;
    gap = idle_enable ? pick_gap() : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= t;
    do @(posedge clk); while (!in_chan.ready);
    ticks_sent++;
  endtask

  task automatic press(logic [3:0] btns);
    send_tick(tick_of(1'b1, btns));
  endtask

  task automatic tap(logic [3:0] btns);
    press(btns);
    press(PRESS_NONE);
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (ticks_checked < ticks_sent) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_entry_mode(logic mode);
    wait_idle();
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= mode;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic test_idle_tick();
    send_tick(tick_of(1'b0, 4'b1111));
  endtask

  task automatic test_digit_wrap();
    tap(PRESS_LEFT | PRESS_UP | PRESS_DOWN);
    tap(PRESS_DOWN);
    tap(PRESS_UP);
    tap(PRESS_DOWN);
  endtask

  task automatic test_ip_overflow();
    press(PRESS_ENTER);
  endtask

  task automatic test_number_mode();
    write_entry_mode(MODE_NUM);
    repeat (3) tap(PRESS_RIGHT);
    tap(PRESS_RIGHT | PRESS_UP);
  endtask

  task automatic test_mode_switch();
    write_entry_mode(MODE_IP);
    tap(PRESS_RIGHT);
    write_entry_mode(MODE_NUM);
    tap(PRESS_RIGHT | PRESS_UP);
    press(PRESS_LEFT);
    press(PRESS_ENTER);
  endtask

  task automatic random_stroke();
    logic [3:0] b;
    logic [3:0] extra;
    int         k;
    int         r;
    k = $urandom_range(0, 99);
    if (k < 80) begin
      r = $urandom_range(0, 99);
      if (r < right_bias) b = PRESS_RIGHT;
      else if (r < right_bias + 12) b = PRESS_LEFT;
      else if (r[0]) b = PRESS_UP;
      else b = PRESS_DOWN;
      press(b);
      if ($urandom_range(0, 9) == 0) send_tick(tick_of(1'b0, 4'($urandom_range(0, 15))));
      press(PRESS_NONE);
    end else if (k < 85) begin
      press(4'($urandom_range(0, 15)));
    end else if (k < 92) begin
      send_tick(tick_of(1'b0, 4'($urandom_range(0, 15))));
    end else if (k < 94) begin
      press(PRESS_ENTER | 4'($urandom_range(0, 15)));
      right_bias = $urandom_range(30, 70);
    end else begin
      b     = PRESS_NONE;
      b[2'($urandom_range(0, 3))] = 1'b1;
      extra = 4'($urandom_range(0, 15));
      press(b);
      press(b | extra);
      press(PRESS_NONE);
    end
  endtask

  task automatic test_random_entries(int total);
    int   phase_end;
    logic mode;
    for (int p = 0; p < 8; p++) begin
      if (p == 0) mode = MODE_IP;
      else if (p == 1) mode = MODE_NUM;
      else mode = logic'($urandom_range(0, 1));
      write_entry_mode(mode);
      idle_enable = (p != 3);
      phase_end   = ticks_sent + total / 8;
      while (ticks_sent < phase_end) random_stroke();
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data  = MODE_IP;
    foreach (shadow_digits[i]) shadow_digits[i] = '0;
    shadow_cursor = '0;
    shadow_prev   = PRESS_NONE;
    shadow_mode   = MODE_IP;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_tick();
    test_digit_wrap();
    test_ip_overflow();
    test_number_mode();
    test_mode_switch();
    test_random_entries(RANDOM_TICKS);

    wait_idle();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    $display("Checked %0d of %0d ticks: %0d confirmed entries, %0d with octet overflow.",
             ticks_checked, ticks_sent, confirm_count, overflow_count);
    $display("Entry mode written %0d times across IPv4 and number entry.", mode_writes);
    if (error_count == 0) begin
      $display("button_digit_entry_editor_unit test passed");
    end else begin
      $display("button_digit_entry_editor_unit test failed");
    end
    $finish;
  end

endmodule
